@@ rtl/core/positional_insert_delete_list_core_macros.svh @@
// Assertion macros shared by the list core's checks.
`ifndef POSITIONAL_INSERT_DELETE_LIST_CORE_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_LIST_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define PIDL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define PIDL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/pidl_pkg.sv @@
// Types, codes and constants shared by the list core modules.
`default_nettype none

package pidl_pkg;

    // Default number of list entries.
    localparam int PIDL_CAPACITY = 16;

    // A dump reports at most this many entries.
    localparam int PIDL_MAX_DUMP = 16;

    localparam int PIDL_FUNC_W  = 3;
    localparam int PIDL_POS_W   = 4;
    localparam int PIDL_WORD_W  = 32;
    localparam int PIDL_COUNT_W = 5;

    // Command function codes.
    localparam logic [PIDL_FUNC_W-1:0] FN_CLEAR  = 3'd0;
    localparam logic [PIDL_FUNC_W-1:0] FN_APPEND = 3'd1;
    localparam logic [PIDL_FUNC_W-1:0] FN_DUMP   = 3'd2;
    localparam logic [PIDL_FUNC_W-1:0] FN_INSERT = 3'd3;
    localparam logic [PIDL_FUNC_W-1:0] FN_DELETE = 3'd4;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // One command word.
    typedef struct packed {
        logic [PIDL_FUNC_W-1:0]         func;
        logic [PIDL_POS_W-1:0]          position;
        logic signed [PIDL_WORD_W-1:0]  value;
    } cmd_t;

    // One result word.
    typedef struct packed {
        status_t                        status;
        logic [PIDL_POS_W-1:0]          index;
        logic signed [PIDL_WORD_W-1:0]  word;
        logic [PIDL_COUNT_W-1:0]        count;
        logic                           last;
    } result_t;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLEAR,
        OP_APPEND,
        OP_INSERT,
        OP_DELETE,
        OP_DUMP,
        OP_ERROR
    } dp_op_t;

    // Controller to datapath.
    typedef struct packed {
        dp_op_t  op;
        status_t err;
    } dp_ctrl_t;

    // Datapath to controller.
    typedef struct packed {
        logic [PIDL_FUNC_W-1:0] func;
        logic                   empty;
        logic                   full;
        logic                   pos_ok;
        logic                   dump_last;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/pidl_ctrl.sv @@
// Command sequencer for the list core: decodes the held command and steps the datapath.
`default_nettype none

module pidl_ctrl
    import pidl_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire dp_stat_t stat,
    output dp_ctrl_t      ctrl,
    output logic          busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DUMP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    // Decode the held command against the list status.
    always_comb
    begin
        ctrl.op    = OP_NOP;
        ctrl.err   = ST_OK;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.op    = OP_LOAD;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                unique case (stat.func)
                    FN_CLEAR:
                    begin
                        ctrl.op = OP_CLEAR;
                    end
                    FN_APPEND:
                    begin
                        if (stat.full)
                        begin
                            ctrl.op  = OP_ERROR;
                            ctrl.err = ST_FULL;
                        end
                        else
                        begin
                            ctrl.op = OP_APPEND;
                        end
                    end
                    FN_DUMP:
                    begin
                        if (stat.empty)
                        begin
                            ctrl.op  = OP_ERROR;
                            ctrl.err = ST_EMPTY;
                        end
                        else
                        begin
                            ctrl.op = OP_DUMP;
                            if (!stat.dump_last)
                            begin
                                state_next = S_DUMP;
                            end
                        end
                    end
                    FN_INSERT:
                    begin
                        priority if (stat.empty)
                        begin
                            ctrl.op  = OP_ERROR;
                            ctrl.err = ST_EMPTY;
                        end
                        else if (!stat.pos_ok)
                        begin
                            ctrl.op  = OP_ERROR;
                            ctrl.err = ST_RANGE;
                        end
                        else if (stat.full)
                        begin
                            ctrl.op  = OP_ERROR;
                            ctrl.err = ST_FULL;
                        end
                        else
                        begin
                            ctrl.op = OP_INSERT;
                        end
                    end
                    FN_DELETE:
                    begin
                        priority if (stat.empty)
                        begin
                            ctrl.op  = OP_ERROR;
                            ctrl.err = ST_EMPTY;
                        end
                        else if (!stat.pos_ok)
                        begin
                            ctrl.op  = OP_ERROR;
                            ctrl.err = ST_RANGE;
                        end
                        else
                        begin
                            ctrl.op = OP_DELETE;
                        end
                    end
                    default:
                    begin
                        // Unused codes are dropped without a result.
                        ctrl.op = OP_NOP;
                    end
                endcase
            end
            S_DUMP:
            begin
                ctrl.op = OP_DUMP;
                if (stat.dump_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and the registered busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

@@ rtl/core/pidl_datapath.sv @@
// List storage, entry count, command hold register and result register.
`default_nettype none

module pidl_datapath
    import pidl_pkg::*;
#(
    parameter int CAPACITY = PIDL_CAPACITY
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cmd_t     cmd,
    input  wire dp_ctrl_t ctrl,
    output dp_stat_t      stat,
    output result_t       result,
    output logic          strobe
);

    localparam int IdxW  = $clog2(CAPACITY);
    localparam int CntW  = $clog2(CAPACITY + 1);
    localparam int WideW = (IdxW > PIDL_POS_W) ? IdxW : PIDL_POS_W;
    localparam int CmpW  = (CntW > PIDL_COUNT_W) ? CntW : PIDL_COUNT_W;

    logic signed [PIDL_WORD_W-1:0] cells_reg [CAPACITY];
    logic signed [PIDL_WORD_W-1:0] up_src    [CAPACITY];
    logic signed [PIDL_WORD_W-1:0] down_src  [CAPACITY];
    cmd_t                          cmd_reg;
    logic [CntW-1:0]               count_reg;
    logic [CntW-1:0]               count_next;
    logic [PIDL_POS_W-1:0]         dump_idx_reg;
    result_t                       result_reg;
    logic                          strobe_reg;

    logic [WideW-1:0] pos_wide;
    logic [WideW-1:0] dump_wide;
    logic [IdxW-1:0]  cell_pos;
    logic [IdxW-1:0]  dump_cell;

    // Neighbor taps for the shifts of insert and delete.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_taps
        if (g == 0)
        begin : g_first
            assign up_src[g] = cells_reg[g];
        end
        else
        begin : g_rest
            assign up_src[g] = cells_reg[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_top
            assign down_src[g] = cells_reg[g];
        end
        else
        begin : g_below
            assign down_src[g] = cells_reg[g+1];
        end
    end

    // Cell indexes taken from the 4-bit position and dump counter.
    assign pos_wide  = WideW'(cmd_reg.position);
    assign dump_wide = WideW'(dump_idx_reg);
    assign cell_pos  = pos_wide[IdxW-1:0];
    assign dump_cell = dump_wide[IdxW-1:0];

    // Status toward the controller.
    assign stat.func      = cmd_reg.func;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CntW'(CAPACITY));
    assign stat.pos_ok    = (CmpW'(cmd_reg.position) < CmpW'(count_reg));
    assign stat.dump_last = ((CmpW'(dump_idx_reg) + CmpW'(1)) == CmpW'(count_reg))
                            || (dump_idx_reg == PIDL_POS_W'(PIDL_MAX_DUMP - 1));

    // Next entry count.
    always_comb
    begin
        count_next = count_reg;
        unique case (ctrl.op)
            OP_CLEAR:  count_next = '0;
            OP_APPEND: count_next = count_reg + CntW'(1);
            OP_INSERT: count_next = count_reg + CntW'(1);
            OP_DELETE: count_next = count_reg - CntW'(1);
            default:   count_next = count_reg;
        endcase
    end

    // Control registers: count, dump counter and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            dump_idx_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            strobe_reg <= (ctrl.op == OP_CLEAR) || (ctrl.op == OP_APPEND)
                          || (ctrl.op == OP_INSERT) || (ctrl.op == OP_DELETE)
                          || (ctrl.op == OP_DUMP) || (ctrl.op == OP_ERROR);
            if (ctrl.op == OP_LOAD)
            begin
                dump_idx_reg <= '0;
            end
            else if (ctrl.op == OP_DUMP)
            begin
                dump_idx_reg <= dump_idx_reg + PIDL_POS_W'(1);
            end
        end
    end

    // Command hold register.
    always_ff @(posedge clk)
    begin
        if (ctrl.op == OP_LOAD)
        begin
            cmd_reg <= cmd;
        end
    end

    // Entry cells: append writes one cell, insert and delete shift a range.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            unique case (ctrl.op)
                OP_APPEND:
                begin
                    if (CntW'(i) == count_reg)
                    begin
                        cells_reg[i] <= cmd_reg.value;
                    end
                end
                OP_INSERT:
                begin
                    if (IdxW'(i) == cell_pos)
                    begin
                        cells_reg[i] <= cmd_reg.value;
                    end
                    else if ((IdxW'(i) > cell_pos) && (CntW'(i) <= count_reg))
                    begin
                        cells_reg[i] <= up_src[i];
                    end
                end
                OP_DELETE:
                begin
                    if ((IdxW'(i) >= cell_pos) && ((CntW'(i) + CntW'(1)) < count_reg))
                    begin
                        cells_reg[i] <= down_src[i];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            OP_CLEAR:
            begin
                result_reg <= '{ST_OK, '0, '0, '0, 1'b1};
            end
            OP_APPEND:
            begin
                result_reg <= '{ST_OK, PIDL_POS_W'(count_reg), cmd_reg.value,
                                PIDL_COUNT_W'(count_next), 1'b1};
            end
            OP_INSERT:
            begin
                result_reg <= '{ST_OK, cmd_reg.position, cmd_reg.value,
                                PIDL_COUNT_W'(count_next), 1'b1};
            end
            OP_DELETE:
            begin
                result_reg <= '{ST_OK, cmd_reg.position, cells_reg[cell_pos],
                                PIDL_COUNT_W'(count_next), 1'b1};
            end
            OP_DUMP:
            begin
                result_reg <= '{ST_OK, dump_idx_reg, cells_reg[dump_cell],
                                PIDL_COUNT_W'(count_reg), stat.dump_last};
            end
            OP_ERROR:
            begin
                result_reg <= '{ctrl.err, '0, '0, PIDL_COUNT_W'(count_reg), 1'b1};
            end
            default:
            begin
            end
        endcase
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule

`default_nettype wire

@@ rtl/core/positional_insert_delete_list_core.sv @@
// Top level of the positional insert/delete list core.
// A command is taken with start, decoded and executed in the next cycle, and its
// first result word shows on result with strobe in the cycle after that.
// A new command is taken only while busy is low, once the last one has executed; a dump gives
// one entry per cycle (at most 16), paced by the single read port onto the entry cells.
// Reset clears the entry count, the sequencer and the strobe; entry cells are not reset.
// The receiver cannot stall: each result word is valid for exactly one cycle.
`default_nettype none

`include "positional_insert_delete_list_core_macros.svh"

module positional_insert_delete_list_core
    import pidl_pkg::*;
#(
    parameter int CAPACITY = PIDL_CAPACITY
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire cmd_t    cmd,
    output logic         busy,
    output result_t      result,
    output logic         strobe
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    // Sequencer.
    pidl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    // Storage and result register.
    pidl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .ctrl   (ctrl),
        .stat   (stat),
        .result (result),
        .strobe (strobe)
    );

    // A taken command keeps the core busy for its execute cycle.
    `PIDL_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command did not raise busy")
    // Every result word comes out of a busy cycle.
    `PIDL_ASSERT_SAME(a_strobe_src, strobe, $past(busy), "result word without a busy cycle")
    // Only a dump in progress gives a word that is not last, and it keeps the core busy.
    `PIDL_ASSERT_SAME(a_mid_dump, strobe && !result.last, busy, "dump word while idle")
    // Error results always end their command.
    `PIDL_ASSERT_SAME(a_err_last, strobe && (result.status != ST_OK), result.last,
        "error result not marked last")

endmodule

`default_nettype wire

@@ test/positional_insert_delete_list_core_tb.sv @@
// Self-checking testbench for the positional insert/delete list core.
`timescale 1ns / 100ps

module positional_insert_delete_list_core_tb;
    import pidl_pkg::*;

    // Function codes the core ignores.
    localparam logic [PIDL_FUNC_W-1:0] FN_RESERVED_FIRST = FN_DELETE + 3'd1;
    localparam logic [PIDL_FUNC_W-1:0] FN_RESERVED_LAST  = 3'd7;

    // Word values at the edges of the signed range.
    localparam logic signed [PIDL_WORD_W-1:0] WORD_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [PIDL_WORD_W-1:0] WORD_MIN  = 32'sh8000_0000;
    localparam logic signed [PIDL_WORD_W-1:0] WORD_ZERO = 32'sh0000_0000;
    localparam logic signed [PIDL_WORD_W-1:0] WORD_ONES = 32'shFFFF_FFFF;

    localparam int RANDOM_CMDS  = 140;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 24;

    // Shadow copy of the list that predicts every result word and checks it.
    class list_shadow;
        logic signed [PIDL_WORD_W-1:0] cells [PIDL_CAPACITY];
        int unsigned                   fill;
        result_t                       due_words [$];
        int                            errors;
        int                            checked;
        int                            status_hits [4];

        function new();
            fill = 0;
            errors = 0;
            checked = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        // Queue one expected word, carrying the count after the command.
        function void expect_word(status_t st, int unsigned idx,
                                  logic signed [PIDL_WORD_W-1:0] w, bit is_last);
            result_t r;
            r.status = st;
            r.index  = idx[PIDL_POS_W-1:0];
            r.word   = w;
            r.count  = fill[PIDL_COUNT_W-1:0];
            r.last   = is_last;
            due_words.push_back(r);
            status_hits[st]++;
        endfunction

        // Apply an accepted command to the shadow list and queue its results.
        function void note_cmd(cmd_t c);
            int unsigned pos;
            int unsigned n;
            logic signed [PIDL_WORD_W-1:0] removed;
            pos = 32'(c.position);
            case (c.func)
                FN_CLEAR:
                begin
                    fill = 0;
                    expect_word(ST_OK, 0, WORD_ZERO, 1'b1);
                end
                FN_APPEND:
                begin
                    if (fill >= PIDL_CAPACITY)
                        expect_word(ST_FULL, 0, WORD_ZERO, 1'b1);
                    else
                    begin
                        cells[fill] = c.value;
                        fill++;
                        expect_word(ST_OK, fill - 1, c.value, 1'b1);
                    end
                end
                FN_DUMP:
                begin
                    if (fill == 0)
                        expect_word(ST_EMPTY, 0, WORD_ZERO, 1'b1);
                    else
                    begin
                        n = (fill < PIDL_MAX_DUMP) ? fill : PIDL_MAX_DUMP;
                        for (int i = 0; i < n; i++)
                            expect_word(ST_OK, i, cells[i], (i + 1) == n);
                    end
                end
                FN_INSERT:
                begin
                    if (fill == 0)
                        expect_word(ST_EMPTY, 0, WORD_ZERO, 1'b1);
                    else if (pos >= fill)
                        expect_word(ST_RANGE, 0, WORD_ZERO, 1'b1);
                    else if (fill >= PIDL_CAPACITY)
                        expect_word(ST_FULL, 0, WORD_ZERO, 1'b1);
                    else
                    begin
                        // Later entries move up one place to open the slot.
                        for (int i = fill; i > pos; i--)
                            cells[i] = cells[i-1];
                        cells[pos] = c.value;
                        fill++;
                        expect_word(ST_OK, pos, c.value, 1'b1);
                    end
                end
                FN_DELETE:
                begin
                    if (fill == 0)
                        expect_word(ST_EMPTY, 0, WORD_ZERO, 1'b1);
                    else if (pos >= fill)
                        expect_word(ST_RANGE, 0, WORD_ZERO, 1'b1);
                    else
                    begin
                        // Later entries move down one place to close the gap.
                        removed = cells[pos];
                        for (int i = pos; i + 1 < fill; i++)
                            cells[i] = cells[i+1];
                        fill--;
                        expect_word(ST_OK, pos, removed, 1'b1);
                    end
                end
                default:
                begin
                    // Reserved codes leave the list alone and give no word.
                end
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        // Compare one result word with the oldest expectation.
        task check_word(result_t got);
            result_t want;
            checked++;
            if (due_words.size() == 0)
            begin
                report($sformatf("result word with nothing expected: %p", got));
                return;
            end
            want = due_words.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.index !== want.index)
                report($sformatf("index %0d, expected %0d", got.index, want.index));
            if (got.word !== want.word)
                report($sformatf("word %h, expected %h", got.word, want.word));
            if (got.count !== want.count)
                report($sformatf("count %0d, expected %0d", got.count, want.count));
            if (got.last !== want.last)
                report($sformatf("last %b, expected %b", got.last, want.last));
        endtask
    endclass

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    cmd_t    cmd;
    logic    busy;
    result_t result;
    logic    strobe;

    list_shadow shadow = new();
    int         cmds_taken;
    int         reserved_taken;
    int         quiet_cycles = 0;

    positional_insert_delete_list_core dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .result (result),
        .strobe (strobe)
    );

    always #2 clk = ~clk;

    // Every result word is checked at the edge that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && strobe === 1'b1)
            shadow.check_word(result);
    end

    // Watchdog: give up when neither side moves a word for too long.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((start && !busy) || strobe)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout after %0d cycles without a handshake.", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic cmd_t make_cmd(logic [PIDL_FUNC_W-1:0] f, int unsigned p,
                                      logic signed [PIDL_WORD_W-1:0] v);
        cmd_t c;
        c.func     = f;
        c.position = p[PIDL_POS_W-1:0];
        c.value    = v;
        return c;
    endfunction

    // Mostly random words, with the range edges mixed in.
    function automatic logic signed [PIDL_WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return WORD_ZERO;
            3:       return WORD_ONES;
            default: return $urandom;
        endcase
    endfunction

    // Random command, weighted so the list grows, fills and drains again.
    function automatic cmd_t pick_cmd();
        int unsigned roll;
        int unsigned pos;
        logic [PIDL_FUNC_W-1:0] f;
        roll = $urandom_range(99);
        if (roll < 30)
            f = FN_APPEND;
        else if (roll < 56)
            f = FN_INSERT;
        else if (roll < 78)
            f = FN_DELETE;
        else if (roll < 90)
            f = FN_DUMP;
        else if (roll < 94)
            f = FN_CLEAR;
        else
            f = PIDL_FUNC_W'($urandom_range(FN_RESERVED_FIRST, FN_RESERVED_LAST));
        if (shadow.fill > 0 && $urandom_range(99) < 80)
            pos = $urandom_range(shadow.fill - 1);
        else
            pos = $urandom_range(15);
        return make_cmd(f, pos, pick_word());
    endfunction

    // Present one command and hold it until the core takes it.
    task automatic send_cmd(cmd_t c, bit may_idle);
        int gap;
        gap = 0;
        if (may_idle)
            while ($urandom_range(99) < 35 && gap < 8)
                gap++;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        shadow.note_cmd(c);
        cmds_taken++;
        if (c.func >= FN_RESERVED_FIRST)
            reserved_taken++;
    endtask

    // Hold the sender off until every expected word has come back.
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (shadow.pending() != 0);
    endtask

    initial
    begin
        int counted;
        cmd_t c;
        cmds_taken     = 0;
        reserved_taken = 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Dump, insert and delete on an empty list, then the ignored codes.
        send_cmd(make_cmd(FN_DUMP,   0,  WORD_ZERO), 1'b1);
        send_cmd(make_cmd(FN_INSERT, 0,  WORD_MAX),  1'b1);
        send_cmd(make_cmd(FN_DELETE, 15, WORD_ZERO), 1'b1);
        for (int f = FN_RESERVED_FIRST; f <= FN_RESERVED_LAST; f++)
            send_cmd(make_cmd(PIDL_FUNC_W'(f), $urandom_range(15), $urandom), 1'b1);

        // Fill the list to capacity, edge values first.
        send_cmd(make_cmd(FN_APPEND, $urandom_range(15), WORD_MAX),  1'b1);
        send_cmd(make_cmd(FN_APPEND, $urandom_range(15), WORD_MIN),  1'b1);
        send_cmd(make_cmd(FN_APPEND, $urandom_range(15), WORD_ZERO), 1'b1);
        send_cmd(make_cmd(FN_APPEND, $urandom_range(15), WORD_ONES), 1'b1);
        while (shadow.fill < PIDL_CAPACITY)
            send_cmd(make_cmd(FN_APPEND, $urandom_range(15), $urandom), 1'b1);

        // Full list: append and insert refused, then a full-length dump.
        send_cmd(make_cmd(FN_APPEND, 0, WORD_ONES), 1'b1);
        send_cmd(make_cmd(FN_INSERT, 0, WORD_ONES), 1'b1);
        send_cmd(make_cmd(FN_DUMP,   0, WORD_ZERO), 1'b1);

        // Edges of the position range: the top entry is deleted, then 15 is out of range; 0 shifts.
        send_cmd(make_cmd(FN_DELETE, 15, WORD_ZERO), 1'b1);
        send_cmd(make_cmd(FN_INSERT, 15, WORD_MIN),  1'b1);
        send_cmd(make_cmd(FN_DELETE, 15, WORD_ZERO), 1'b1);
        send_cmd(make_cmd(FN_INSERT, 0,  WORD_MIN),  1'b1);
        send_cmd(make_cmd(FN_DELETE, 0,  WORD_ZERO), 1'b1);
        send_cmd(make_cmd(FN_DUMP,   0,  WORD_ZERO), 1'b1);
        send_cmd(make_cmd(FN_CLEAR,  $urandom_range(15), $urandom), 1'b1);

        // Random commands; a long stretch in the middle runs back to back.
        counted = 0;
        while (counted < RANDOM_CMDS)
        begin
            if (counted == RANDOM_CMDS / 2)
                drain();
            c = pick_cmd();
            send_cmd(c, !(counted >= 60 && counted < 120));
            if (c.func < FN_RESERVED_FIRST)
                counted++;
        end

        // Let everything settle, then allow for any stray late word.
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Took %0d commands (%0d with reserved codes), checked %0d result words.",
                 cmds_taken, reserved_taken, shadow.checked);
        $display("Predicted status mix: ok %0d, empty %0d, range %0d, full %0d.",
                 shadow.status_hits[ST_OK], shadow.status_hits[ST_EMPTY],
                 shadow.status_hits[ST_RANGE], shadow.status_hits[ST_FULL]);
        if (shadow.errors == 0 && shadow.pending() == 0)
            $display("All tests passed");
        else
        begin
            if (shadow.pending() != 0)
                $display("%0d expected result words never arrived.", shadow.pending());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/pidl_pkg.sv
rtl/core/pidl_ctrl.sv
rtl/core/pidl_datapath.sv
rtl/core/positional_insert_delete_list_core.sv
test/positional_insert_delete_list_core_tb.sv
